### sv/bce_pkg.sv
// bce_pkg: shared type, constants and elaboration-time helpers of the
// breathing colour effect. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bce_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PERIOD   = 3'd0,
    CFG_GAIN     = 3'd1,
    CFG_DSEED    = 3'd2,
    CFG_HSEED    = 3'd3,
    CFG_SAT_BASE = 3'd4,
    CFG_SAT_SPAN = 3'd5
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // reset values of the registers
  localparam logic [15:0] PERIOD_RST   = 16'd7800;
  localparam logic [7:0]  GAIN_RST     = 8'd176;
  localparam logic [7:0]  DSEED_RST    = 8'd87;
  localparam logic [7:0]  HSEED_RST    = 8'd39;
  localparam logic [7:0]  SAT_BASE_RST = 8'd236;
  localparam logic [7:0]  SAT_SPAN_RST = 8'd19;

  // hash multipliers
  localparam logic [31:0] HASH_M1 = 32'h7FEB352D;
  localparam logic [31:0] HASH_M2 = 32'h846CA68B;

  // wave floor, 0.018 in q0.16
  localparam logic [16:0] WAVE_FLOOR = 17'd1180;

  // smoother constants
  localparam logic [15:0] LOW_TARGET  = 16'd768;
  localparam logic [15:0] HUE_TARGET  = 16'd512;
  localparam logic [15:0] SNAP_GAP    = 16'd96;
  localparam logic [7:0]  DARK_FRAC   = 8'd48;
  localparam logic [7:0]  UP_SLOW     = 8'd224;
  localparam logic [7:0]  UP_MID      = 8'd182;
  localparam logic [7:0]  UP_FAST     = 8'd142;
  localparam logic [7:0]  DN_A        = 8'd255;
  localparam logic [7:0]  DN_B        = 8'd236;
  localparam logic [7:0]  DN_C        = 8'd204;
  localparam logic [7:0]  DN_D        = 8'd170;
  localparam logic [7:0]  DITH_T_MUL  = 8'd29;
  localparam logic [7:0]  DITH_S_MUL  = 8'd53;

  // floor square root, used only while building the curve table
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bv;
    res = '0;
    rem = v;
    for (int k = 31; k >= 0; k--) begin
      bv = 64'd1 << (2 * k);
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // one curve entry 1-(1-x)^1.75 from u = 1-x in q0.16
  function automatic logic [16:0] curve_from_u(input logic [16:0] u);
    logic [63:0] uu;
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] p;
    uu = 64'(u);
    s  = isqrt64(uu << 16);
    r  = isqrt64(s << 16);
    p  = (((uu * s) >> 16) * r) >> 16;
    return 17'(64'd65536 - p);
  endfunction

  // x / 255 for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

### sv/bce_if.sv
// bce_if: valid/ready stream interfaces for frame requests and colours.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bce_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  frame_brightness;

  modport source (output valid, now_ms, frame_brightness, input ready);
  modport sink   (input valid, now_ms, frame_brightness, output ready);
endinterface

interface bce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] out_brightness;

  modport source (output valid, red, green, blue, out_brightness, input ready);
  modport sink   (input valid, red, green, blue, out_brightness, output ready);
endinterface

`default_nettype wire

### sv/breathe_color_effect_top.sv
// breathe_color_effect_top: sequencer of the breathing colour effect.
// uses bce_pkg, bce_if, bce_div, bce_mul and bce_curve_rom.
//
//   channel   dir  payload                               handshake
//   in_ch     in   now_ms, frame_brightness              valid / ready
//   out_ch    out  red, green, blue, out_brightness      valid / ready
//   cfg       in   cfg_index, cfg_data                   cfg_we
//
// a transaction runs from acceptance to a colour on out_ch through a wait on
// the 48-step divider and then steps that use one shared multiplier in turn;
// the rising half of the wave takes more steps than the falling half, and a
// short period skips the wave. the next request is taken the cycle after the colour is formed.
// rst is synchronous and returns the registers to their defaults and the
// level to zero. a colour waits in the output register until taken; if it is
// still waiting when the next colour is ready the sequencer holds at its last step.
`timescale 1ns / 1ps
`default_nettype none

module breathe_color_effect_top
  import bce_pkg::*;
#(
  parameter int unsigned CURVE_TABLE_DEPTH = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  bce_in_if.sink                     in_ch,
  bce_out_if.source                  out_ch
);

  localparam int unsigned AW = $clog2(CURVE_TABLE_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_RPOS, ST_RDA, ST_RDB, ST_RINT, ST_RN,
    ST_FSQ, ST_FCU, ST_FN, ST_FLOOR, ST_WAVE, ST_TGT,
    ST_SMA, ST_SMB, ST_SMC, ST_H1, ST_H2, ST_H3, ST_SAT, ST_SAT2,
    ST_HSV1, ST_HSV2, ST_HSV3, ST_HSV4, ST_HSV5, ST_HSV6
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] period_len;
  logic [7:0]  peak_gain;
  logic [7:0]  dither_seed;
  logic [7:0]  hue_seed;
  logic [7:0]  sat_base;
  logic [7:0]  sat_span;

  // working registers
  logic [31:0] now_r;
  logic [7:0]  bri_r;
  logic [31:0] cyc_r;
  logic [15:0] ph_r;
  logic [AW-1:0] idx_r;
  logic [15:0] f_r;
  logic [16:0] ea_r;
  logic        rise_up_r;
  logic [16:0] n_r;
  logic [15:0] w_r;
  logic [15:0] target_r;
  logic [15:0] tz_r;
  logic        up_r;
  logic [15:0] gap_r;
  logic [7:0]  alpha_r;
  logic [31:0] hx_r;
  logic [7:0]  vout_r;
  logic [7:0]  hue_r;
  logic [7:0]  sat_r;
  logic [2:0]  sect_r;
  logic [7:0]  rem_r;
  logic [7:0]  sr_r;
  logic [7:0]  st_r;
  logic [7:0]  p_r;
  logic [7:0]  q_r;

  // persistent state
  logic [15:0] level_q8;
  logic        lat_valid;
  logic [31:0] lat_cyc;
  logic [7:0]  lat_hue;

  // shared units
  logic        div_start;
  logic        div_done;
  logic [47:0] div_quot;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [AW-1:0] rom_addr;
  logic [16:0] rom_q;

  logic        in_acc;
  logic        out_acc;
  logic        out_load;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign div_start   = in_acc;

  // last step may fill the output register once it is empty or being taken
  assign out_load = (state == ST_HSV6) && (!out_ch.valid || out_ch.ready);

  bce_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({in_ch.now_ms, 16'h0000}),
    .divisor  (period_len),
    .done     (div_done),
    .quot     (div_quot)
  );

  bce_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  bce_curve_rom #(.DEPTH(CURVE_TABLE_DEPTH)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  // derived values
  logic [15:0] x_c;
  logic [AW-1:0] idx_c;
  logic [16:0] diff_c;
  logic [16:0] nf_c;
  logic [32:0] wsum_c;
  logic [15:0] tgt_c;
  logic [15:0] tz_c;
  logic [7:0]  lv8;
  logic [31:0] hraw_c;
  logic [31:0] hy_c;
  logic [31:0] hz_c;
  logic [15:0] mag_c;
  logic [16:0] up_sum_c;
  logic [15:0] lvl_next_c;
  logic [7:0]  thr_c;
  logic [7:0]  vint_c;
  logic [8:0]  sat_sum_c;
  logic [2:0]  sect_c;
  logic [7:0]  sect_base_c;
  logic [7:0]  off6_c;
  logic [7:0]  t_c;

  // wave position, shared by both halves
  assign x_c = {ph_r[14:0], 1'b0};

  always_comb begin
    idx_c = prod[16 +: AW];
    if (idx_c >= AW'(CURVE_TABLE_DEPTH)) begin
      idx_c = AW'(CURVE_TABLE_DEPTH - 1);
    end
  end

  assign rom_addr = (state == ST_RDA) ? idx_c : idx_r + AW'(1);
  assign diff_c   = (rom_q >= ea_r) ? rom_q - ea_r : ea_r - rom_q;
  assign nf_c     = (n_r < WAVE_FLOOR) ? 17'd0 : n_r;
  assign wsum_c   = prod[32:0] + 33'd32768;

  // target and smoother inputs
  assign tgt_c = prod[23:8];
  assign tz_c  = (tgt_c <= LOW_TARGET) ? 16'd0 : tgt_c;
  assign lv8   = level_q8[15:8];

  // hash input: seed alone when the period is zero
  assign hraw_c = (period_len == 16'd0) ? 32'(hue_seed) : cyc_r + 32'(hue_seed);
  assign hy_c   = prod[31:0] ^ (prod[31:0] >> 15);
  assign hz_c   = prod[31:0] ^ (prod[31:0] >> 16);

  // level step
  always_comb begin
    mag_c = prod[23:8];
    if (mag_c == 16'd0) begin
      mag_c = 16'd1;
    end
    up_sum_c = 17'(level_q8) + 17'(mag_c);
    if (gap_r < SNAP_GAP) begin
      lvl_next_c = tz_r;
    end else if (up_r) begin
      lvl_next_c = up_sum_c[16] ? 16'hFFFF : up_sum_c[15:0];
    end else begin
      lvl_next_c = (mag_c > level_q8) ? 16'd0 : level_q8 - mag_c;
    end
  end

  // dither of the level fraction
  always_comb begin
    thr_c  = 8'(now_r[7:0] * DITH_T_MUL) + 8'(dither_seed * DITH_S_MUL);
    vint_c = level_q8[15:8];
    if (level_q8[15:8] == 8'd0 && level_q8[7:0] < DARK_FRAC) begin
      vint_c = 8'd0;
    end else if (level_q8[7:0] > thr_c && level_q8[15:8] != 8'hFF) begin
      vint_c = level_q8[15:8] + 8'd1;
    end
  end

  assign sat_sum_c = 9'(sat_base) + 9'(div255(prod[15:0]));

  // hue sector and offset within it
  always_comb begin
    priority if (hue_r >= 8'd215) begin
      sect_c = 3'd5; sect_base_c = 8'd215;
    end else if (hue_r >= 8'd172) begin
      sect_c = 3'd4; sect_base_c = 8'd172;
    end else if (hue_r >= 8'd129) begin
      sect_c = 3'd3; sect_base_c = 8'd129;
    end else if (hue_r >= 8'd86) begin
      sect_c = 3'd2; sect_base_c = 8'd86;
    end else if (hue_r >= 8'd43) begin
      sect_c = 3'd1; sect_base_c = 8'd43;
    end else begin
      sect_c = 3'd0; sect_base_c = 8'd0;
    end
    off6_c = 8'((hue_r - sect_base_c) * 8'd6);
  end

  assign t_c = div255(prod[15:0]);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_RPOS: begin
        mul_a = 32'(x_c); mul_b = 32'(CURVE_TABLE_DEPTH);
      end
      ST_RINT: begin
        mul_a = 32'(diff_c); mul_b = 32'(f_r);
      end
      ST_FSQ: begin
        mul_a = 32'(x_c); mul_b = 32'(x_c);
      end
      ST_FCU: begin
        mul_a = 32'(prod[31:16]); mul_b = 32'(x_c);
      end
      ST_FLOOR: begin
        mul_a = 32'(nf_c); mul_b = 32'd65535;
      end
      ST_TGT: begin
        mul_a = 32'(peak_gain); mul_b = 32'(w_r);
      end
      ST_SMB: begin
        mul_a = 32'(gap_r); mul_b = 32'(alpha_r);
      end
      ST_H1: begin
        mul_a = hx_r; mul_b = HASH_M1;
      end
      ST_H2: begin
        mul_a = hy_c; mul_b = HASH_M2;
      end
      ST_SAT: begin
        mul_a = 32'(vout_r); mul_b = 32'(sat_span);
      end
      ST_HSV1: begin
        mul_a = 32'(sat_r); mul_b = 32'(rem_r);
      end
      ST_HSV2: begin
        mul_a = 32'(sat_r); mul_b = 32'(8'hFF - rem_r);
      end
      ST_HSV3: begin
        mul_a = 32'(vout_r); mul_b = 32'(8'hFF - sat_r);
      end
      ST_HSV4: begin
        mul_a = 32'(vout_r); mul_b = 32'(8'hFF - sr_r);
      end
      // last product is kept while the output register is still full
      ST_HSV5, ST_HSV6: begin
        mul_a = 32'(vout_r); mul_b = 32'(8'hFF - st_r);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_len  <= PERIOD_RST;
      peak_gain   <= GAIN_RST;
      dither_seed <= DSEED_RST;
      hue_seed    <= HSEED_RST;
      sat_base    <= SAT_BASE_RST;
      sat_span    <= SAT_SPAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD:   period_len  <= cfg_data;
        CFG_GAIN:     peak_gain   <= cfg_data[7:0];
        CFG_DSEED:    dither_seed <= cfg_data[7:0];
        CFG_HSEED:    hue_seed    <= cfg_data[7:0];
        CFG_SAT_BASE: sat_base    <= cfg_data[7:0];
        CFG_SAT_SPAN: sat_span    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_ch.valid <= 1'b0;
      level_q8     <= '0;
      lat_valid    <= 1'b0;
      lat_cyc      <= '1;
      lat_hue      <= '0;
    end else begin
      // output register: filled by the last step, emptied by the receiver
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_acc) begin
        out_ch.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            now_r <= in_ch.now_ms;
            bri_r <= in_ch.frame_brightness;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cyc_r <= div_quot[47:16];
            ph_r  <= div_quot[15:0];
            if (period_len < 16'd2) begin
              w_r   <= 16'hFFFF;
              state <= ST_TGT;
            end else if (!div_quot[15]) begin
              state <= ST_RPOS;
            end else begin
              state <= ST_FSQ;
            end
          end
        end
        ST_RPOS: state <= ST_RDA;
        ST_RDA: begin
          idx_r <= idx_c;
          f_r   <= prod[15:0];
          state <= ST_RDB;
        end
        ST_RDB: begin
          ea_r  <= rom_q;
          state <= ST_RINT;
        end
        ST_RINT: begin
          rise_up_r <= (rom_q >= ea_r);
          state     <= ST_RN;
        end
        ST_RN: begin
          n_r   <= rise_up_r ? ea_r + prod[32:16] : ea_r - prod[32:16];
          state <= ST_FLOOR;
        end
        ST_FSQ: state <= ST_FCU;
        ST_FCU: state <= ST_FN;
        ST_FN: begin
          n_r   <= 17'h10000 - 17'(prod[31:16]);
          state <= ST_FLOOR;
        end
        ST_FLOOR: state <= ST_WAVE;
        ST_WAVE: begin
          w_r   <= (wsum_c[32]) ? 16'hFFFF : wsum_c[31:16];
          state <= ST_TGT;
        end
        ST_TGT: state <= ST_SMA;
        ST_SMA: begin
          target_r <= tgt_c;
          tz_r     <= tz_c;
          up_r     <= (tz_c > level_q8);
          gap_r    <= (tz_c > level_q8) ? tz_c - level_q8 : level_q8 - tz_c;
          if (tz_c > level_q8) begin
            alpha_r <= (lv8 < 8'd20) ? UP_SLOW : (lv8 < 8'd80) ? UP_MID : UP_FAST;
          end else begin
            alpha_r <= (lv8 < 8'd20) ? DN_A : (lv8 < 8'd64) ? DN_B :
                       (lv8 < 8'd132) ? DN_C : DN_D;
          end
          hx_r  <= hraw_c ^ (hraw_c >> 16);
          state <= ST_SMB;
        end
        ST_SMB: state <= ST_SMC;
        ST_SMC: begin
          level_q8 <= lvl_next_c;
          state    <= ST_H1;
        end
        ST_H1: begin
          vout_r <= vint_c;
          state  <= ST_H2;
        end
        ST_H2: state <= ST_H3;
        ST_H3: begin
          // hue latch (unused at period 0): first hue, then per new cycle near the dark floor
          if (period_len == 16'd0) begin
            hue_r <= hz_c[7:0];
          end else if (!lat_valid || (cyc_r != lat_cyc && target_r <= HUE_TARGET)) begin
            lat_valid <= 1'b1;
            lat_cyc   <= cyc_r;
            lat_hue   <= hz_c[7:0];
            hue_r     <= hz_c[7:0];
          end else begin
            hue_r <= lat_hue;
          end
          state <= ST_SAT;
        end
        ST_SAT: state <= ST_SAT2;
        ST_SAT2: begin
          sat_r  <= sat_sum_c[8] ? 8'hFF : sat_sum_c[7:0];
          sect_r <= sect_c;
          rem_r  <= off6_c;
          state  <= ST_HSV1;
        end
        ST_HSV1: state <= ST_HSV2;
        ST_HSV2: begin
          sr_r  <= div255(prod[15:0]);
          state <= ST_HSV3;
        end
        ST_HSV3: begin
          st_r  <= div255(prod[15:0]);
          state <= ST_HSV4;
        end
        ST_HSV4: begin
          p_r   <= div255(prod[15:0]);
          state <= ST_HSV5;
        end
        ST_HSV5: begin
          q_r   <= div255(prod[15:0]);
          state <= ST_HSV6;
        end
        ST_HSV6: begin
          if (out_load) begin
            unique case (sect_r)
              3'd0: begin
                out_ch.red <= vout_r; out_ch.green <= t_c; out_ch.blue <= p_r;
              end
              3'd1: begin
                out_ch.red <= q_r; out_ch.green <= vout_r; out_ch.blue <= p_r;
              end
              3'd2: begin
                out_ch.red <= p_r; out_ch.green <= vout_r; out_ch.blue <= t_c;
              end
              3'd3: begin
                out_ch.red <= p_r; out_ch.green <= q_r; out_ch.blue <= vout_r;
              end
              3'd4: begin
                out_ch.red <= t_c; out_ch.green <= p_r; out_ch.blue <= vout_r;
              end
              default: begin
                out_ch.red <= vout_r; out_ch.green <= p_r; out_ch.blue <= q_r;
              end
            endcase
            out_ch.out_brightness <= bri_r;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("sequencer did not start after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.red) &&
      $stable(out_ch.green) && $stable(out_ch.blue) && $stable(out_ch.out_brightness))
    else $error("colour changed while waiting to be taken");

  a_wait_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_HSV6 && out_ch.valid && !out_ch.ready |=> state == ST_HSV6)
    else $error("colour formed while the output register was full");

  a_div_only_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

### sv/bce_div.sv
// bce_div: restoring divider, one quotient bit per cycle, 48-bit dividend
// by 16-bit divisor. uses bce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bce_div
  import bce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [47:0]      quot
);

  localparam int unsigned STEPS = 48;

  logic [5:0]  cnt;
  logic        running;
  logic [16:0] rem;
  logic [16:0] trial;
  logic        fits;

  // one restoring step
  assign trial = {rem[15:0], quot[47]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= 6'(STEPS);
        quot    <= dividend;
        rem     <= '0;
      end else if (running) begin
        rem  <= fits ? (trial - {1'b0, divisor}) : trial;
        quot <= {quot[46:0], fits};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### sv/bce_mul.sv
// bce_mul: shared 32x32 multiplier with registered product.
// uses bce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bce_mul
  import bce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [63:0]      prod
);

  // product is registered, landing in the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

`default_nettype wire

### sv/bce_curve_rom.sv
// bce_curve_rom: rising-edge curve table with registered read, built at
// elaboration. uses bce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bce_curve_rom
  import bce_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(DEPTH+1)-1:0] addr,
  output logic [16:0]                     data
);

  logic [16:0] rom [0:DEPTH];

  // entry i samples the curve at x = i / DEPTH
  for (genvar i = 0; i <= DEPTH; i++) begin : g_ent
    localparam logic [16:0] UVAL = 17'(65536 - ((i * 65536) / DEPTH));
    assign rom[i] = curve_from_u(UVAL);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

`default_nettype wire
